// File: hdl/prt_pkg.sv
// ----------------------------------------------------------------------------
// prt_pkg
// Shared constants, state encoding and control bundles of the percentile
// rank tracker.
// ----------------------------------------------------------------------------
package prt_pkg;

  // default sizing
  localparam int NUM_USERS_DEF = 131072;
  localparam int MAX_LEVEL_DEF = 1024;

  // request field widths
  localparam int UID_IN_W = 17;
  localparam int LVL_IN_W = 11;

  // operation codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // saturating counters
  localparam int               CNT_W   = 18;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // unsigned q1.20 result
  localparam int                FRAC_SHIFT = 20;
  localparam int                FRAC_W     = FRAC_SHIFT + 1;
  localparam logic [FRAC_W-1:0] FRAC_ONE   = FRAC_W'(1) << FRAC_SHIFT;

  // divider sizing: one quotient bit per dividend bit
  localparam int DIV_N  = CNT_W + FRAC_SHIFT;
  localparam int STEP_W = $clog2(DIV_N);

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_WALK,
    S_QREAD,
    S_DIV,
    S_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic clr_en;
    logic in_ready;
    logic capture;
    logic upd_start;
    logic res_special;
    logic walk_en;
    logic div_start;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic upd_ok;
    logic is_query;
    logic need_div;
    logic walk_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// File: hdl/prt_in_if.sv
// ----------------------------------------------------------------------------
// prt_in_if
// Request channel: operation, user index and level with valid/ready.
// ----------------------------------------------------------------------------
interface prt_in_if;

  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [prt_pkg::UID_IN_W-1:0] user_id;
  logic [prt_pkg::LVL_IN_W-1:0] level;

  modport source (output valid, output operation, output user_id, output level,
                  input ready);
  modport sink   (input valid, input operation, input user_id, input level,
                  output ready);

endinterface

// File: hdl/prt_out_if.sv
// ----------------------------------------------------------------------------
// prt_out_if
// Result channel: q1.20 rank fraction with valid/ready.
// ----------------------------------------------------------------------------
interface prt_out_if;

  logic                        valid;
  logic                        ready;
  logic [prt_pkg::FRAC_W-1:0] rank_fraction;

  modport source (output valid, output rank_fraction, input ready);
  modport sink   (input valid, input rank_fraction, output ready);

endinterface

// File: hdl/prt_div.sv
// ----------------------------------------------------------------------------
// prt_div
// Restoring divider, one quotient bit per cycle: (dividend << 20) / divisor,
// saturated to 1.0 in q1.20.
// ----------------------------------------------------------------------------
module prt_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [prt_pkg::CNT_W-1:0]   dividend,
  input  logic [prt_pkg::CNT_W-1:0]   divisor,
  output logic                        done,
  output logic [prt_pkg::FRAC_W-1:0]  quotient
);

  localparam int CW = prt_pkg::CNT_W;
  localparam int FW = prt_pkg::FRAC_W;
  localparam int DN = prt_pkg::DIV_N;
  localparam int SW = prt_pkg::STEP_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [DN-1:0] dsh_r, dsh_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] dvs_r, dvs_nxt;
  logic [FW-1:0] quo_r, quo_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW:0]   trial;
  logic          ge;

  // one restoring step
  assign trial = {rem_r, dsh_r[DN-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dsh_nxt  = dsh_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    ovf_nxt  = ovf_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dsh_nxt  = {dividend, {prt_pkg::FRAC_SHIFT{1'b0}}};
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = '0;
      ovf_nxt  = 1'b0;
    end else if (busy_r) begin
      dsh_nxt  = {dsh_r[DN-2:0], 1'b0};
      rem_nxt  = ge ? CW'(trial - {1'b0, dvs_r}) : trial[CW-1:0];
      quo_nxt  = {quo_r[FW-2:0], ge};
      ovf_nxt  = ovf_r | quo_r[FW-1];
      step_nxt = step_r + SW'(1);
      if (step_r == SW'(DN - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    dsh_r <= dsh_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
  end

  // saturate above 1.0
  assign done     = done_r;
  assign quotient = (ovf_r || (quo_r[FW-1] && (quo_r[FW-2:0] != '0)))
                    ? prt_pkg::FRAC_ONE : quo_r;

endmodule

// File: hdl/prt_dp.sv
// ----------------------------------------------------------------------------
// prt_dp
// Datapath: user level memory, per-level count memory, known user counter,
// count walk pipeline, divider and the result register.
// ----------------------------------------------------------------------------
module prt_dp #(
  parameter int NUM_USERS = prt_pkg::NUM_USERS_DEF,
  parameter int MAX_LEVEL = prt_pkg::MAX_LEVEL_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  prt_pkg::cmd_t                 cmd,
  input  logic                          in_operation,
  input  logic [prt_pkg::UID_IN_W-1:0]  in_user_id,
  input  logic [prt_pkg::LVL_IN_W-1:0]  in_level,
  input  logic                          out_ready,
  output prt_pkg::status_t              status,
  output logic                          out_valid,
  output logic [prt_pkg::FRAC_W-1:0]    out_rank_fraction
);

  localparam int UID_W = $clog2(NUM_USERS);
  localparam int LVL_W = $clog2(MAX_LEVEL + 1);
  localparam int PTR_W = LVL_W + 1;
  localparam int CLR_N = (NUM_USERS > MAX_LEVEL + 1) ? NUM_USERS : MAX_LEVEL + 1;
  localparam int CLR_W = $clog2(CLR_N);
  localparam int CW    = prt_pkg::CNT_W;
  localparam int FW    = prt_pkg::FRAC_W;

  // memories: user entry is {seen, level}
  logic [LVL_W:0]  u_mem [NUM_USERS];
  logic [CW-1:0]   c_mem [MAX_LEVEL + 1];

  logic [CLR_W-1:0] clr_cnt_r;
  logic [UID_W-1:0] uaddr_r;
  logic [LVL_W-1:0] lvl_r;
  logic             op_r;
  logic             range_r;
  logic [LVL_W:0]   u_rdata_r;
  logic [CW-1:0]    c_rdata_r;
  logic [CW-1:0]    known_r, known_nxt;
  logic [PTR_W-1:0] p_r, p_nxt;
  logic [PTR_W-1:0] hi_r, hi_nxt;
  logic             inc_r, inc_nxt;
  logic             pend_r, pend_nxt;
  logic [LVL_W-1:0] waddr_r;
  logic [FW-1:0]    res_r;
  logic             out_valid_r;
  logic [FW-1:0]    out_data_r;

  logic             u_seen;
  logic [LVL_W-1:0] u_lvl;
  logic             seen_q;
  logic             in_range;
  logic [LVL_W-1:0] in_lvl_sat;
  logic [UID_W-1:0] in_uaddr;
  logic [LVL_W-1:0] c_raddr;
  logic             walk_go;
  logic [CW-1:0]    c_mod;
  logic             div_done;
  logic [FW-1:0]    div_q;

  // request decode
  assign in_range   = 32'(in_user_id) < NUM_USERS;
  assign in_uaddr   = UID_W'(32'(in_user_id));
  assign in_lvl_sat = (32'(in_level) > MAX_LEVEL) ? LVL_W'(MAX_LEVEL) : LVL_W'(in_level);

  assign u_seen = u_rdata_r[LVL_W];
  assign u_lvl  = u_rdata_r[LVL_W-1:0];
  assign seen_q = u_seen & range_r;

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_en && !status.clr_done) begin
      clr_cnt_r <= clr_cnt_r + CLR_W'(1);
    end
  end

  // request capture and user lookup
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r      <= in_operation;
      range_r   <= in_range;
      uaddr_r   <= in_uaddr;
      lvl_r     <= in_lvl_sat;
      u_rdata_r <= u_mem[in_uaddr];
    end
  end

  // user memory write port
  always_ff @(posedge clk) begin
    if (cmd.clr_en && (32'(clr_cnt_r) < NUM_USERS)) begin
      u_mem[clr_cnt_r[UID_W-1:0]] <= '0;
    end else if (cmd.upd_start) begin
      u_mem[uaddr_r] <= {1'b1, lvl_r};
    end
  end

  // walk bounds, pointer and write tracking
  assign walk_go = cmd.walk_en && (p_r <= hi_r);

  always_comb begin
    p_nxt     = p_r;
    hi_nxt    = hi_r;
    inc_nxt   = inc_r;
    known_nxt = known_r;
    pend_nxt  = walk_go;
    if (cmd.upd_start) begin
      inc_nxt = !u_seen;
      if (u_seen) begin
        p_nxt  = PTR_W'(u_lvl) + PTR_W'(1);
        hi_nxt = PTR_W'(lvl_r);
      end else begin
        p_nxt  = PTR_W'(lvl_r) + PTR_W'(1);
        hi_nxt = PTR_W'(MAX_LEVEL);
        if (known_r != prt_pkg::CNT_MAX) begin
          known_nxt = known_r + CW'(1);
        end
      end
    end else if (walk_go) begin
      p_nxt = p_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r <= '0;
      pend_r  <= 1'b0;
      p_r     <= '0;
      hi_r    <= '0;
      inc_r   <= 1'b0;
    end else begin
      known_r <= known_nxt;
      pend_r  <= pend_nxt;
      p_r     <= p_nxt;
      hi_r    <= hi_nxt;
      inc_r   <= inc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (walk_go) begin
      waddr_r <= p_r[LVL_W-1:0];
    end
  end

  // count memory read port: walk pointer or the queried user's level
  assign c_raddr = cmd.walk_en ? p_r[LVL_W-1:0] : u_lvl;

  always_ff @(posedge clk) begin
    c_rdata_r <= c_mem[c_raddr];
  end

  // saturating increment or floored decrement
  always_comb begin
    if (inc_r) begin
      c_mod = (c_rdata_r == prt_pkg::CNT_MAX) ? c_rdata_r : c_rdata_r + CW'(1);
    end else begin
      c_mod = (c_rdata_r == '0) ? c_rdata_r : c_rdata_r - CW'(1);
    end
  end

  // count memory write port
  always_ff @(posedge clk) begin
    if (cmd.clr_en && (32'(clr_cnt_r) <= MAX_LEVEL)) begin
      c_mem[clr_cnt_r[LVL_W-1:0]] <= '0;
    end else if (pend_r) begin
      c_mem[waddr_r] <= c_mod;
    end
  end

  // divider for the rank share
  prt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (c_rdata_r),
    .divisor  (known_r - CW'(1)),
    .done     (div_done),
    .quotient (div_q)
  );

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_special) begin
      res_r <= (seen_q && (known_r == CW'(1))) ? prt_pkg::FRAC_ONE : '0;
    end else if (div_done) begin
      res_r <= div_q;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_rank_fraction = out_data_r;

  // status to the controller
  always_comb begin
    status.clr_done  = clr_cnt_r == CLR_W'(CLR_N - 1);
    status.upd_ok    = range_r;
    status.is_query  = op_r == prt_pkg::OP_QUERY;
    status.need_div  = seen_q && (known_r >= CW'(2));
    status.walk_done = (p_r > hi_r) && !pend_r;
    status.div_done  = div_done;
    status.out_free  = !out_valid_r || out_ready;
  end

`ifndef SYNTHESIS
  // walk writes stay inside the level range
  a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (32'(waddr_r) <= MAX_LEVEL))
    else $error("count write beyond top level");

  // known user count never goes down
  a_known_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (known_r >= $past(known_r)))
    else $error("known user count decreased");

  // a result is loaded only into a free output register
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result overwrote a pending result");
`endif

endmodule

// File: hdl/prt_ctrl.sv
// ----------------------------------------------------------------------------
// prt_ctrl
// Controller: sequences clearing, user lookup, count walk, division and
// result hand-off.
// ----------------------------------------------------------------------------
module prt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  prt_pkg::status_t  status,
  output prt_pkg::cmd_t     cmd
);

  prt_pkg::state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prt_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prt_pkg::S_CLEAR: begin
        if (status.clr_done) state_nxt = prt_pkg::S_IDLE;
      end
      prt_pkg::S_IDLE: begin
        if (in_valid) state_nxt = prt_pkg::S_LOOK;
      end
      prt_pkg::S_LOOK: begin
        if (status.is_query) begin
          state_nxt = status.need_div ? prt_pkg::S_QREAD : prt_pkg::S_RESULT;
        end else begin
          state_nxt = status.upd_ok ? prt_pkg::S_WALK : prt_pkg::S_IDLE;
        end
      end
      prt_pkg::S_WALK: begin
        if (status.walk_done) state_nxt = prt_pkg::S_IDLE;
      end
      prt_pkg::S_QREAD: begin
        state_nxt = prt_pkg::S_DIV;
      end
      prt_pkg::S_DIV: begin
        if (status.div_done) state_nxt = prt_pkg::S_RESULT;
      end
      prt_pkg::S_RESULT: begin
        if (status.out_free) state_nxt = prt_pkg::S_IDLE;
      end
      default: begin
        state_nxt = prt_pkg::S_CLEAR;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd             = '0;
    cmd.clr_en      = state_r == prt_pkg::S_CLEAR;
    cmd.in_ready    = state_r == prt_pkg::S_IDLE;
    cmd.capture     = (state_r == prt_pkg::S_IDLE) && in_valid;
    cmd.upd_start   = (state_r == prt_pkg::S_LOOK) && !status.is_query && status.upd_ok;
    cmd.res_special = (state_r == prt_pkg::S_LOOK) && status.is_query && !status.need_div;
    cmd.walk_en     = state_r == prt_pkg::S_WALK;
    cmd.div_start   = state_r == prt_pkg::S_QREAD;
    cmd.out_load    = (state_r == prt_pkg::S_RESULT) && status.out_free;
  end

`ifndef SYNTHESIS
  // divider finishes only while waiting for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    status.div_done |-> (state_r == prt_pkg::S_DIV))
    else $error("divider done outside division");

  // an accepted request always goes to lookup
  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == prt_pkg::S_LOOK))
    else $error("accepted request skipped lookup");

  // division leads only to the result
  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == prt_pkg::S_DIV) |=>
      ((state_r == prt_pkg::S_DIV) || (state_r == prt_pkg::S_RESULT)))
    else $error("division left without a result");
`endif

endmodule

// File: hdl/percentile_rank_tracker_unit.sv
// ----------------------------------------------------------------------------
// percentile_rank_tracker_unit
// Per-user progress levels with per-level counts of lower users; answers the
// share of other users below a given user as an unsigned q1.20 fraction.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    operation, user_id, level
//  out_ch   out  valid/ready    rank_fraction (query requests only)
//
//  after reset a clearing pass over max(NUM_USERS, MAX_LEVEL+1) entries runs
//  (131072 by default) with in_ch.ready low
//  update: walks the count entries one after another (up to MAX_LEVEL of
//  them) through the single read-modify-write port of the count memory
//  query: goes through the 38-step bit-serial divider, which is skipped
//  when no division is needed
//  a pending result in the output register does not block the next request,
//  but the next query result waits until it is taken
//
module percentile_rank_tracker_unit #(
  parameter int NUM_USERS = prt_pkg::NUM_USERS_DEF,
  parameter int MAX_LEVEL = prt_pkg::MAX_LEVEL_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  prt_in_if.sink     in_ch,
  prt_out_if.source  out_ch
);

  prt_pkg::cmd_t    cmd;
  prt_pkg::status_t status;

  // sequencing
  prt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .status   (status),
    .cmd      (cmd)
  );

  // storage and arithmetic
  prt_dp #(
    .NUM_USERS (NUM_USERS),
    .MAX_LEVEL (MAX_LEVEL)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_operation      (in_ch.operation),
    .in_user_id        (in_ch.user_id),
    .in_level          (in_ch.level),
    .out_ready         (out_ch.ready),
    .status            (status),
    .out_valid         (out_ch.valid),
    .out_rank_fraction (out_ch.rank_fraction)
  );

  assign in_ch.ready = cmd.in_ready;

endmodule
